[rtl/ssd_pkg.sv]
// Shared types, constants and the glyph table for the seven-segment serial driver.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package ssd_pkg;

	localparam int NumDigitsDefault = 8;
	localparam int QueueDepth       = 2;
	localparam int PatternWidth     = 8;
	localparam int SelectWidth      = 3;
	localparam int BitCountWidth    = $clog2(PatternWidth);

	// Item kind codes
	localparam logic [1:0] KIND_RAW   = 2'd0;
	localparam logic [1:0] KIND_DIGIT = 2'd1;
	localparam logic [1:0] KIND_CHAR  = 2'd2;

	localparam logic [7:0] CHAR_DASH       = 8'h2d;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CHAR_ZERO       = 8'h30;
	localparam logic [7:0] CHAR_NINE       = 8'h39;

	localparam logic [7:0] GLYPH_DASH       = 8'h40;
	localparam logic [7:0] GLYPH_UNDERSCORE = 8'h08;
	localparam logic [7:0] DOT_MASK         = 8'h80;

	// One classified byte waiting for the shifter
	typedef struct packed {
		logic [SelectWidth-1:0]  sel;
		logic [PatternWidth-1:0] pattern;
	} seg_entry_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Common-cathode glyph for 0..9; callers guarantee the range
	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'd0: g = 8'h3f;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5b;
			4'd3: g = 8'h4f;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6d;
			4'd6: g = 8'h7d;
			4'd7: g = 8'h07;
			4'd8: g = 8'h7f;
			4'd9: g = 8'h6f;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

[rtl/ssd_front.sv]
// Front end: accepts items, builds the segment byte and tracks the digit select.
// Depends on ssd_pkg; writes classified bytes into ssd_queue.
`timescale 1ns / 1ps

module ssd_front #(
	parameter int NUM_DIGITS = ssd_pkg::NumDigitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [1:0]          kind,
	input  logic [7:0]          position,
	input  logic [7:0]          value,
	input  logic                dot,
	input  ssd_pkg::q_status_t  q_status,
	output logic                full,
	output logic                q_push,
	output ssd_pkg::seg_entry_t q_wdata
);

	logic [ssd_pkg::SelectWidth-1:0] select_q;
	logic [ssd_pkg::SelectWidth-1:0] select_next;
	logic [7:0]                      pattern;
	logic                            has_pattern;
	logic                            accept;
	logic                            pos_ok;
	logic [7:0]                      char_off;

	assign full     = q_status.full;
	assign accept   = push && !q_status.full;
	assign pos_ok   = position < 8'(NUM_DIGITS);
	assign char_off = value - ssd_pkg::CHAR_ZERO;

	// Classify the beat
	always_comb begin
		pattern     = value;
		has_pattern = 1'b0;
		case (kind)
			ssd_pkg::KIND_RAW: begin
				has_pattern = 1'b1;
			end
			ssd_pkg::KIND_DIGIT: begin
				has_pattern = value <= 8'd9;
				pattern     = ssd_pkg::glyph(value[3:0]) | (dot ? ssd_pkg::DOT_MASK : 8'h00);
			end
			ssd_pkg::KIND_CHAR: begin
				if (value == ssd_pkg::CHAR_DASH) begin
					has_pattern = 1'b1;
					pattern     = ssd_pkg::GLYPH_DASH;
				end else if (value == ssd_pkg::CHAR_UNDERSCORE) begin
					has_pattern = 1'b1;
					pattern     = ssd_pkg::GLYPH_UNDERSCORE;
				end else begin
					has_pattern = value >= ssd_pkg::CHAR_ZERO && value <= ssd_pkg::CHAR_NINE;
					pattern     = ssd_pkg::glyph(char_off[3:0]);
				end
			end
			default: begin
				has_pattern = 1'b0;
			end
		endcase
	end

	// Hold the select unless a producing beat names a valid position
	assign select_next = (has_pattern && pos_ok) ?
		position[ssd_pkg::SelectWidth-1:0] : select_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q <= '0;
		end else if (accept) begin
			select_q <= select_next;
		end
	end

	// Drop beats that give no pattern
	assign q_push          = accept && has_pattern;
	assign q_wdata.sel     = select_next;
	assign q_wdata.pattern = pattern;

endmodule

[rtl/ssd_queue.sv]
// Short FIFO of classified bytes between front end and shifter.
// Depends on ssd_pkg for the entry and status types.
`timescale 1ns / 1ps

module ssd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  ssd_pkg::seg_entry_t wdata,
	input  logic                rd,
	output ssd_pkg::seg_entry_t rdata,
	output ssd_pkg::q_status_t  status
);

	localparam int Depth = ssd_pkg::QueueDepth;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	ssd_pkg::seg_entry_t mem_q [Depth];
	logic [PtrW-1:0]     wptr_q;
	logic [PtrW-1:0]     rptr_q;
	logic [CntW-1:0]     count_q;

	assign status.full  = count_q == CntW'(Depth);
	assign status.empty = count_q == '0;
	assign rdata        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !status.full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !status.empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

[rtl/ssd_back.sv]
// Back end: shifts each queued byte out MSB first, one result per pop.
// Depends on ssd_pkg; reads bytes from ssd_queue.
`timescale 1ns / 1ps

module ssd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ssd_pkg::q_status_t              q_status,
	input  ssd_pkg::seg_entry_t             q_rdata,
	output logic                            q_pop,
	input  logic                            pop,
	output logic                            empty,
	output logic [ssd_pkg::SelectWidth-1:0] digit_select,
	output logic                            serial_bit,
	output logic                            latch
);

	logic                              busy_q;
	logic [ssd_pkg::BitCountWidth-1:0] cnt_q;
	logic [ssd_pkg::PatternWidth-1:0]  shift_q;
	logic [ssd_pkg::SelectWidth-1:0]   sel_q;
	logic                              taken;
	logic                              last;

	assign empty        = !busy_q;
	assign digit_select = sel_q;
	assign serial_bit   = shift_q[ssd_pkg::PatternWidth-1];
	assign last         = cnt_q == ssd_pkg::BitCountWidth'(ssd_pkg::PatternWidth - 1);
	assign latch        = last;
	assign taken        = pop && busy_q;
	// Load a new byte when idle or as the last bit leaves
	assign q_pop        = !q_status.empty && (!busy_q || (taken && last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			shift_q <= q_rdata.pattern;
			sel_q   <= q_rdata.sel;
		end else if (taken) begin
			shift_q <= {shift_q[ssd_pkg::PatternWidth-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (taken) begin
			busy_q <= !last;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0) else $error("bit count not cleared when idle");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(taken && !last) |=> busy_q && cnt_q == $past(cnt_q) + 1'b1)
		else $error("shifter failed to advance");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(taken && last && q_status.empty) |=> empty) else $error("shifter stuck after byte");

endmodule

[rtl/seven_segment_serial_driver.sv]
// Top level of the seven-segment serial driver: front end, byte queue, shifter.
// Depends on ssd_pkg, ssd_front, ssd_queue and ssd_back.
`timescale 1ns / 1ps

// Takes one display beat (kind, position, value, dot) and turns it into an
// 8-bit common-cathode segment byte (bit 7 is the decimal point), which is
// then shifted out MSB first as eight result beats, each carrying the 3-bit
// digit select; the eighth beat has latch set. Raw beats send value as is,
// digit beats take 0..9 plus dot, character beats take '-', '_' and '0'..'9'.
// Anything else is dropped with no result and no change of select. A
// position at or above NUM_DIGITS keeps the previous select but the byte is
// still sent. The shifter emits one bit per pop, and a two-entry byte queue
// lets the input side take beats back to back while the shifter is busy,
// until the queue is full. When the shifter is idle, a pushed byte is written
// to the queue and then loaded into the shifter before its first result.
module seven_segment_serial_driver #(
	parameter int NUM_DIGITS = ssd_pkg::NumDigitsDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input side
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      kind,
	input  logic [7:0]                      position,
	input  logic [7:0]                      value,
	input  logic                            dot,
	// result side
	output logic                            empty,
	input  logic                            pop,
	output logic [ssd_pkg::SelectWidth-1:0] digit_select,
	output logic                            serial_bit,
	output logic                            latch
);

	ssd_pkg::q_status_t  q_status;
	ssd_pkg::seg_entry_t q_wdata;
	ssd_pkg::seg_entry_t q_rdata;
	logic                q_push;
	logic                q_pop;

	// Classify beats and keep the digit select
	ssd_front #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.kind     (kind),
		.position (position),
		.value    (value),
		.dot      (dot),
		.q_status (q_status),
		.full     (full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// Buffer bytes so the front can keep taking beats while the shifter is mid-byte, until the queue is full
	ssd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	// Shift bytes out one bit per result beat
	ssd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.digit_select (digit_select),
		.serial_bit   (serial_bit),
		.latch        (latch)
	);

endmodule
